// ===== sv/swss_pkg.sv =====
`default_nettype none
package swss_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  localparam logic [15:0] TPS_RESET   = 16'd40;
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;
  localparam logic [5:0]  MIN_PER_HR  = 6'd60;
  localparam logic [4:0]  HR_PER_DAY  = 5'd24;
  localparam logic [6:0]  DAY_LAST    = 7'd99;
  localparam logic [7:0]  SEG_DP      = 8'h80;

  typedef struct packed {
    logic [6:0] days;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } clock_time_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== sv/swss_time_core.sv =====
`default_nettype none
module swss_time_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  fire,
  input  wire logic [1:0]            op,
  input  wire logic [15:0]           tps,
  output swss_pkg::clock_time_t      time_nxt,
  output logic                       counting_nxt
);

  logic [15:0]           sub_r, sub_nxt;
  swss_pkg::clock_time_t time_r;
  logic                  counting_r;
  logic [16:0]           sub_inc;

  assign sub_inc = {1'b0, sub_r} + 17'd1;

  always_comb begin
    sub_nxt      = sub_r;
    time_nxt     = time_r;
    counting_nxt = counting_r;
    case (swss_pkg::op_t'(op))
      swss_pkg::OP_TICK: begin
        if (counting_r) begin
          if (sub_inc < {1'b0, tps}) begin
            sub_nxt = sub_inc[15:0];
          end else begin
            sub_nxt = '0;
            // cascade of rollovers: seconds -> minutes -> hours -> days
            if (time_r.seconds + 6'd1 < swss_pkg::SEC_PER_MIN) begin
              time_nxt.seconds = time_r.seconds + 6'd1;
            end else begin
              time_nxt.seconds = '0;
              if (time_r.minutes + 6'd1 < swss_pkg::MIN_PER_HR) begin
                time_nxt.minutes = time_r.minutes + 6'd1;
              end else begin
                time_nxt.minutes = '0;
                if (time_r.hours + 5'd1 < swss_pkg::HR_PER_DAY) begin
                  time_nxt.hours = time_r.hours + 5'd1;
                end else begin
                  time_nxt.hours = '0;
                  time_nxt.days  = (time_r.days >= swss_pkg::DAY_LAST) ? 7'd0
                                                                       : time_r.days + 7'd1;
                end
              end
            end
          end
        end
      end
      swss_pkg::OP_START: counting_nxt = 1'b1;
      swss_pkg::OP_STOP:  counting_nxt = 1'b0;
      default: begin
        counting_nxt = 1'b0;
        sub_nxt      = '0;
        time_nxt     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r      <= '0;
      time_r     <= '0;
      counting_r <= 1'b0;
    end else if (fire) begin
      sub_r      <= sub_nxt;
      time_r     <= time_nxt;
      counting_r <= counting_nxt;
    end
  end

  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    time_r.seconds < swss_pkg::SEC_PER_MIN && time_r.minutes < swss_pkg::MIN_PER_HR)
    else $error("minutes/seconds out of range");

  a_hr_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    time_r.hours < swss_pkg::HR_PER_DAY && time_r.days <= swss_pkg::DAY_LAST)
    else $error("hours/days out of range");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op == swss_pkg::OP_CLEAR |=> !counting_r && sub_r == '0 && time_r == '0)
    else $error("clear did not stop and zero the count");

  a_stopped_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !counting_r && op == swss_pkg::OP_TICK |=> $stable(time_r) && $stable(sub_r))
    else $error("time moved while stopped");

endmodule
`default_nettype wire

// ===== sv/swss_seg_enc.sv =====
`default_nettype none
module swss_seg_enc (
  input  wire swss_pkg::clock_time_t t,
  input  wire logic [2:0]            digit_index,
  output logic [7:0]                 segments
);

  logic [6:0]  val;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [3:0]  units;

  always_comb begin
    case (digit_index[2:1])
      2'd0:    val = t.days;
      2'd1:    val = {2'b00, t.hours};
      2'd2:    val = {1'b0, t.minutes};
      default: val = {1'b0, t.seconds};
    endcase
  end

  // val < 100, so val*205 >> 11 is exactly val/10
  assign prod     = {8'd0, val} * 15'd205;
  assign tens     = prod[14:11];
  assign tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
  assign units    = 4'(val - tens_x10);

  always_comb begin
    if (digit_index[0]) begin
      segments = swss_pkg::seg_of(units) | swss_pkg::SEG_DP;
    end else if (tens == 4'd0) begin
      segments = 8'h00;
    end else begin
      segments = swss_pkg::seg_of(tens);
    end
  end

endmodule
`default_nettype wire

// ===== sv/stopwatch_with_seven_segment_scan.sv =====
// Two register stages (input register, then result register); an event held in the input
// register moves to the result register, raising out_valid, once that stage is empty or read.
// One item per cycle when out_ready holds.
// Throughput is set by the single register stage that applies the event and encodes the digit.
// Reset (rst_n low, synchronous): stopped, all counters zero, ticks_per_second 40,
// both pipeline registers empty.
`default_nettype none
module stopwatch_with_seven_segment_scan (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [2:0]  in_digit_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_segments,
  output logic [2:0]       out_digit_select,
  output logic             out_running
);

  logic [15:0]           tps_r;
  logic                  in_vld_r;
  logic [1:0]            op_r;
  logic [2:0]            idx_r;
  logic                  out_vld_r;
  logic [7:0]            seg_r;
  logic [2:0]            sel_r;
  logic                  run_r;
  logic                  fire;
  swss_pkg::clock_time_t time_nxt;
  logic                  counting_nxt;
  logic [7:0]            seg_nxt;

  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= swss_pkg::TPS_RESET;
    end else if (cfg_we) begin
      tps_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_operation;
      idx_r <= in_digit_index;
    end
  end

  swss_time_core u_time (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .op           (op_r),
    .tps          (tps_r),
    .time_nxt     (time_nxt),
    .counting_nxt (counting_nxt)
  );

  swss_seg_enc u_enc (
    .t           (time_nxt),
    .digit_index (idx_r),
    .segments    (seg_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      seg_r <= seg_nxt;
      sel_r <= idx_r;
      run_r <= counting_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_segments     = seg_r;
  assign out_digit_select = sel_r;
  assign out_running      = run_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |-> !fire)
    else $error("result overwritten before transfer");

  a_units_dp: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> seg_r[7] == sel_r[0])
    else $error("decimal point on wrong digit");

  a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r && sel_r == $past(idx_r))
    else $error("stage transfer lost");

endmodule
`default_nettype wire

// ===== tb/tb_stopwatch_with_seven_segment_scan.sv =====
`timescale 1ns / 1ps
module tb_stopwatch_with_seven_segment_scan;

  localparam int PIPE_LATENCY   = 2;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_RUN_TICKS = 150;

  typedef struct packed {
    swss_pkg::op_t op;
    logic [2:0]    idx;
  } sw_event_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [2:0] digit_select;
    logic       running;
  } display_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = '0;
  logic [2:0]  in_digit_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_segments;
  logic [2:0]  out_digit_select;
  logic        out_running;

  stopwatch_with_seven_segment_scan u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_digit_index   (in_digit_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segments     (out_segments),
    .out_digit_select (out_digit_select),
    .out_running      (out_running)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the stopwatch
  logic [15:0] sw_tps;
  logic [15:0] sw_sub;
  logic [5:0]  sw_sec;
  logic [5:0]  sw_min;
  logic [4:0]  sw_hr;
  logic [6:0]  sw_day;
  logic        sw_run;

  sw_event_t event_q[$];
  display_t  display_q[$];
  sw_event_t drv_ev;
  display_t  got_disp;
  display_t  want_disp;

  int  send_idle_pct = 9;
  int  recv_idle_pct = 81;
  int  events_queued = 0;
  int  events_taken  = 0;
  int  results_seen  = 0;
  int  mismatch_count = 0;
  int  idle_cycles   = 0;
  int  tps_writes    = 0;
  logic in_fire = 1'b0;

  function automatic logic [7:0] glyph(input int d);
    logic [7:0] g;
    case (d)
      0: g = 8'h3f;
      1: g = 8'h06;
      2: g = 8'h5b;
      3: g = 8'h4f;
      4: g = 8'h66;
      5: g = 8'h6d;
      6: g = 8'h7d;
      7: g = 8'h07;
      8: g = 8'h7f;
      default: g = 8'h6f;
    endcase
    return g;
  endfunction

  // applies one event to the shadow state, returns the digit it then shows
  function automatic display_t apply_event(input sw_event_t ev);
    display_t d;
    logic [16:0] nxt;
    int v;
    case (ev.op)
      swss_pkg::OP_TICK: begin
        if (sw_run) begin
          nxt = {1'b0, sw_sub} + 17'd1;
          if (nxt < {1'b0, sw_tps}) begin
            sw_sub = nxt[15:0];
          end else begin
            sw_sub = '0;
            if (sw_sec != swss_pkg::SEC_PER_MIN - 6'd1) begin
              sw_sec = sw_sec + 6'd1;
            end else begin
              sw_sec = '0;
              if (sw_min != swss_pkg::MIN_PER_HR - 6'd1) begin
                sw_min = sw_min + 6'd1;
              end else begin
                sw_min = '0;
                if (sw_hr != swss_pkg::HR_PER_DAY - 5'd1) begin
                  sw_hr = sw_hr + 5'd1;
                end else begin
                  sw_hr = '0;
                  sw_day = (sw_day >= swss_pkg::DAY_LAST) ? 7'd0 : sw_day + 7'd1;
                end
              end
            end
          end
        end
      end
      swss_pkg::OP_START: sw_run = 1'b1;
      swss_pkg::OP_STOP:  sw_run = 1'b0;
      default: begin
        sw_run = 1'b0;
        sw_sub = '0;
        sw_sec = '0;
        sw_min = '0;
        sw_hr  = '0;
        sw_day = '0;
      end
    endcase
    case (ev.idx[2:1])
      2'd0:    v = int'(sw_day);
      2'd1:    v = int'(sw_hr);
      2'd2:    v = int'(sw_min);
      default: v = int'(sw_sec);
    endcase
    v = v % 100;
    if (ev.idx[0])
      d.segments = glyph(v % 10) | swss_pkg::SEG_DP;
    else
      d.segments = (v / 10 == 0) ? 8'h00 : glyph(v / 10);
    d.digit_select = ev.idx;
    d.running = sw_run;
    return d;
  endfunction

  // driver: new payload only once the previous one has transferred
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_ev = event_q.pop_front();
          in_valid <= 1'b1;
          in_operation <= drv_ev.op;
          in_digit_index <= drv_ev.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
      sw_tps = swss_pkg::TPS_RESET;
      sw_sub = '0;
      sw_sec = '0;
      sw_min = '0;
      sw_hr  = '0;
      sw_day = '0;
      sw_run = 1'b0;
    end else begin
      if (cfg_we)
        sw_tps = cfg_wdata;
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        display_q.push_back(apply_event('{swss_pkg::op_t'(in_operation), in_digit_index}));
        events_taken++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        got_disp = '{out_segments, out_digit_select, out_running};
        if (display_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: seg=%02h sel=%0d run=%0b",
                     got_disp.segments, got_disp.digit_select, got_disp.running);
          mismatch_count++;
        end else begin
          want_disp = display_q.pop_front();
          if (got_disp.segments !== want_disp.segments ||
              got_disp.digit_select !== want_disp.digit_select ||
              got_disp.running !== want_disp.running) begin
            if (mismatch_count < 10)
              $display("mismatch %0t: exp seg=%02h sel=%0d run=%0b got seg=%02h sel=%0d run=%0b",
                       $realtime, want_disp.segments, want_disp.digit_select,
                       want_disp.running, got_disp.segments, got_disp.digit_select,
                       got_disp.running);
            mismatch_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL stopwatch_with_seven_segment_scan");
        $finish;
      end
    end
  end

  task automatic push_event(input swss_pkg::op_t op, input logic [2:0] idx);
    event_q.push_back('{op, idx});
    events_queued++;
  endtask

  function automatic logic [2:0] any_digit();
    return 3'($urandom_range(7));
  endfunction

  // sender holds off until every transfer has produced its result
  task automatic drain();
    while (events_queued != events_taken || display_q.size() != 0)
      @(negedge clk);
    repeat (PIPE_LATENCY + 1) @(negedge clk);
  endtask

  task automatic write_tps(input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    tps_writes++;
    @(posedge clk);
  endtask

  // mostly start followed by a burst of ticks, with stray presses mixed in
  task automatic random_events(input int count);
    int made;
    int pick;
    int burst;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        burst = $urandom_range(40, 1);
        push_event(swss_pkg::OP_START, any_digit());
        repeat (burst) push_event(swss_pkg::OP_TICK, any_digit());
        made += burst + 1;
      end else if (pick < 75) begin
        push_event(swss_pkg::OP_STOP, any_digit());
        made++;
      end else if (pick < 83) begin
        push_event(swss_pkg::OP_CLEAR, any_digit());
        made++;
      end else begin
        push_event(swss_pkg::op_t'($urandom_range(3)), any_digit());
        made++;
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // directed, reset value of the register
    push_event(swss_pkg::OP_TICK, 3'd0);     // tick while stopped
    push_event(swss_pkg::OP_STOP, 3'd7);     // stop while stopped
    push_event(swss_pkg::OP_START, 3'd1);
    push_event(swss_pkg::OP_START, 3'd7);    // start while running
    push_event(swss_pkg::OP_TICK, 3'd6);
    push_event(swss_pkg::OP_TICK, 3'd5);
    push_event(swss_pkg::OP_TICK, 3'd4);
    push_event(swss_pkg::OP_STOP, 3'd3);
    push_event(swss_pkg::OP_TICK, 3'd2);
    push_event(swss_pkg::OP_START, 3'd0);
    push_event(swss_pkg::OP_CLEAR, 3'd7);    // reset while running
    push_event(swss_pkg::OP_TICK, 3'd7);
    for (int i = 0; i < 8; i++)
      push_event(swss_pkg::OP_STOP, 3'(i));
    push_event(swss_pkg::OP_CLEAR, 3'd0);    // reset while stopped
    drain();

    write_tps(16'd2);
    random_events(240);
    drain();

    // sub-tick count left above a smaller register value
    write_tps(16'hffff);
    push_event(swss_pkg::OP_START, 3'd7);
    repeat (30) push_event(swss_pkg::OP_TICK, any_digit());
    push_event(swss_pkg::OP_STOP, 3'd7);
    drain();
    write_tps(16'd3);
    push_event(swss_pkg::OP_START, 3'd7);
    push_event(swss_pkg::OP_TICK, 3'd7);
    push_event(swss_pkg::OP_TICK, 3'd6);
    push_event(swss_pkg::OP_STOP, 3'd7);
    drain();

    // zero behaves as one
    send_idle_pct = 81;
    recv_idle_pct = 9;
    write_tps(16'd0);
    random_events(240);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_tps(16'($urandom_range(6, 1)));
    random_events(230);
    drain();

    // one second per tick, long enough to roll the minutes and light the tens digits
    write_tps(16'd1);
    push_event(swss_pkg::OP_CLEAR, any_digit());
    push_event(swss_pkg::OP_START, any_digit());
    repeat (LONG_RUN_TICKS) push_event(swss_pkg::OP_TICK, any_digit());
    push_event(swss_pkg::OP_STOP, 3'd0);
    for (int i = 0; i < 8; i++)
      push_event(swss_pkg::OP_TICK, 3'(i));
    drain();

    if (display_q.size() != 0)
      mismatch_count++;
    $display("covered %0d event transfers and %0d checked results over %0d register writes",
             events_taken, results_seen, tps_writes);
    $display("long run stopped at day %0d %0d:%0d:%0d, mismatches %0d",
             sw_day, sw_hr, sw_min, sw_sec, mismatch_count);
    if (mismatch_count == 0)
      $display("PASS stopwatch_with_seven_segment_scan");
    else
      $display("FAIL stopwatch_with_seven_segment_scan");
    $finish;
  end

endmodule
